// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the heap queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define HPQ_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define HPQ_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define HPQ_ASSERT(name, prop, msg)
`define HPQ_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

// ===== rtl/hpq_pkg.sv =====
// Types and constants of the heap priority queue.
package hpq_pkg;

    localparam int KEY_W     = 32;
    localparam int CAP_W     = 11;
    localparam int OCC_W     = 11;
    localparam int STAT_W    = 2;
    localparam int M_TDATA_W = 48;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;
    localparam logic [KEY_W-1:0] KEY_EMPTY = '1;
    localparam logic [KEY_W-1:0] KEY_NONE  = '0;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } hpq_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INS_RD,
        ST_INS_CMP,
        ST_REM_LAST,
        ST_REM_CUR,
        ST_DN_RDL,
        ST_DN_RDR,
        ST_DN_CMP,
        ST_DONE
    } hpq_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_FULL,
        OP_EMPTY,
        OP_INS_INIT,
        OP_WR_CUR,
        OP_RD_PARENT,
        OP_INS_CMP,
        OP_RD_ROOT,
        OP_RD_LAST,
        OP_GET_CUR,
        OP_RD_LEFT,
        OP_RD_RIGHT,
        OP_DN_CMP,
        OP_EMIT
    } hpq_op_t;

    typedef struct packed {
        hpq_op_t op;
    } hpq_cmd_t;

    typedef struct packed {
        logic is_insert;
        logic full;
        logic empty;
        logic at_root;
        logic has_left;
        logic parent_less;
        logic move_down;
        logic out_free;
    } hpq_status_t;

endpackage

// ===== rtl/hpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/hpq_ctrl.sv =====
// Sequencer of the heap queue: walks insert, remove and sift steps.
`include "assert_macros.svh"

module hpq_ctrl import hpq_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  hpq_status_t status,
    output hpq_cmd_t    cmd
);

    hpq_state_t state_reg;
    hpq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (status.is_insert)
                begin
                    state_next = status.full ? ST_DONE : ST_INS_RD;
                end
                else
                begin
                    state_next = status.empty ? ST_DONE : ST_REM_LAST;
                end
            end
            ST_INS_RD:   state_next = status.at_root ? ST_DONE : ST_INS_CMP;
            ST_INS_CMP:  state_next = status.parent_less ? ST_INS_RD : ST_DONE;
            ST_REM_LAST: state_next = ST_REM_CUR;
            ST_REM_CUR:  state_next = ST_DN_RDL;
            ST_DN_RDL:   state_next = status.has_left ? ST_DN_RDR : ST_DONE;
            ST_DN_RDR:   state_next = ST_DN_CMP;
            ST_DN_CMP:   state_next = status.move_down ? ST_DN_RDL : ST_DONE;
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd.op   = OP_NONE;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.op = OP_ACCEPT;
                end
            end
            ST_DISPATCH:
            begin
                if (status.is_insert)
                begin
                    cmd.op = status.full ? OP_FULL : OP_INS_INIT;
                end
                else
                begin
                    cmd.op = status.empty ? OP_EMPTY : OP_RD_ROOT;
                end
            end
            ST_INS_RD:   cmd.op = status.at_root ? OP_WR_CUR : OP_RD_PARENT;
            ST_INS_CMP:  cmd.op = OP_INS_CMP;
            ST_REM_LAST: cmd.op = OP_RD_LAST;
            ST_REM_CUR:  cmd.op = OP_GET_CUR;
            ST_DN_RDL:   cmd.op = status.has_left ? OP_RD_LEFT : OP_WR_CUR;
            ST_DN_RDR:   cmd.op = OP_RD_RIGHT;
            ST_DN_CMP:   cmd.op = OP_DN_CMP;
            ST_DONE:     cmd.op = status.out_free ? OP_EMIT : OP_NONE;
            default:     cmd.op = OP_NONE;
        endcase
    end

    `HPQ_ASSERT_NEXT(a_accept_dispatch, s_tvalid && s_tready, state_reg == ST_DISPATCH, "accepted beat not dispatched")
    `HPQ_ASSERT(a_ins_not_full, cmd.op == OP_INS_INIT |-> !status.full, "insert started on full heap")

endmodule

// ===== rtl/hpq_dp.sv =====
// Datapath of the heap queue: key store, count, sift registers, result register.
`include "assert_macros.svh"

module hpq_dp import hpq_pkg::*; #(
    parameter int DEPTH = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hpq_cmd_t             cmd,
    output hpq_status_t          status,
    input  logic                 cfg_we,
    input  logic [CAP_W-1:0]     cfg_wdata,
    input  logic [KEY_W-1:0]     in_key,
    input  logic                 in_cmd,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [STAT_W-1:0]    m_tuser
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (AW + 2 > CAP_W) ? AW + 2 : CAP_W;

    logic [CAP_W-1:0]        cap_reg;
    logic                    cmd_reg;
    logic signed [KEY_W-1:0] key_in_reg;
    logic signed [KEY_W-1:0] cur_key_reg;
    logic signed [KEY_W-1:0] lkey_reg;
    logic [AW-1:0]           idx_reg;
    logic [CW-1:0]           count_reg;
    hpq_stat_t               res_stat_reg;
    logic [KEY_W-1:0]        res_key_reg;
    logic                    out_valid_reg;
    hpq_stat_t               out_stat_reg;
    logic [KEY_W-1:0]        out_key_reg;
    logic [OCC_W-1:0]        out_occ_reg;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [KEY_W-1:0]        ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [KEY_W-1:0]        ram_rdata;
    logic signed [KEY_W-1:0] rkey;

    logic [XW-1:0]           count_x;
    logic [XW-1:0]           left_x;
    logic [XW-1:0]           right_x;
    logic [XW-1:0]           cap_x;
    logic [XW-1:0]           depth_x;
    logic [XW-1:0]           limit_x;
    logic [AW-1:0]           parent_idx;
    logic [AW-1:0]           left_idx;
    logic [AW-1:0]           right_idx;
    logic [AW-1:0]           last_idx;
    logic                    has_right;
    logic                    pick_left;
    logic                    pick_right;
    logic signed [KEY_W-1:0] pick_key;
    logic                    out_free;

    assign rkey       = signed'(ram_rdata);
    assign count_x    = XW'(count_reg);
    assign left_x     = (XW'(idx_reg) << 1) | XW'(1);
    assign right_x    = left_x + XW'(1);
    assign cap_x      = XW'(cap_reg);
    assign depth_x    = XW'(DEPTH);
    assign limit_x    = (cap_x > depth_x) ? depth_x : cap_x;
    assign parent_idx = AW'((idx_reg - AW'(1)) >> 1);
    assign left_idx   = left_x[AW-1:0];
    assign right_idx  = right_x[AW-1:0];
    assign last_idx   = AW'(count_reg - CW'(1));
    assign has_right  = right_x < count_x;

    // larger child beats the moving key only if strictly larger
    assign pick_left  = lkey_reg > cur_key_reg;
    assign pick_key   = pick_left ? lkey_reg : cur_key_reg;
    assign pick_right = has_right && (rkey > pick_key);
    assign out_free   = !out_valid_reg || m_tready;

    always_comb
    begin
        status.is_insert   = (cmd_reg == CMD_INSERT);
        status.full        = count_x >= limit_x;
        status.empty       = (count_reg == '0);
        status.at_root     = (idx_reg == '0);
        status.has_left    = left_x < count_x;
        status.parent_less = rkey < cur_key_reg;
        status.move_down   = pick_left || pick_right;
        status.out_free    = out_free;
    end

    // memory ports
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = cur_key_reg;
        ram_raddr = '0;
        case (cmd.op)
            OP_WR_CUR:    ram_we = 1'b1;
            OP_RD_PARENT: ram_raddr = parent_idx;
            OP_INS_CMP:
            begin
                ram_we    = 1'b1;
                ram_wdata = status.parent_less ? ram_rdata : cur_key_reg;
            end
            OP_RD_ROOT:   ram_raddr = '0;
            OP_RD_LAST:   ram_raddr = last_idx;
            OP_RD_LEFT:   ram_raddr = left_idx;
            OP_RD_RIGHT:  ram_raddr = right_idx;
            OP_DN_CMP:
            begin
                ram_we = 1'b1;
                if (pick_right)
                begin
                    ram_wdata = ram_rdata;
                end
                else if (pick_left)
                begin
                    ram_wdata = lkey_reg;
                end
            end
            default:      ram_we = 1'b0;
        endcase
    end

    hpq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            case (cmd.op)
                OP_INS_INIT: count_reg <= count_reg + CW'(1);
                OP_RD_LAST:  count_reg <= count_reg - CW'(1);
                default:     count_reg <= count_reg;
            endcase
            if (cmd.op == OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_ACCEPT:
            begin
                cmd_reg    <= in_cmd;
                key_in_reg <= signed'(in_key);
            end
            OP_FULL:
            begin
                res_stat_reg <= STAT_FULL;
                res_key_reg  <= KEY_NONE;
            end
            OP_EMPTY:
            begin
                res_stat_reg <= STAT_EMPTY;
                res_key_reg  <= KEY_EMPTY;
            end
            OP_INS_INIT:
            begin
                idx_reg      <= AW'(count_reg);
                cur_key_reg  <= key_in_reg;
                res_stat_reg <= STAT_OK;
                res_key_reg  <= KEY_NONE;
            end
            OP_INS_CMP:
            begin
                if (status.parent_less)
                begin
                    idx_reg <= parent_idx;
                end
            end
            OP_RD_LAST:
            begin
                res_stat_reg <= STAT_OK;
                res_key_reg  <= ram_rdata;
                idx_reg      <= '0;
            end
            OP_GET_CUR:   cur_key_reg <= rkey;
            OP_RD_RIGHT:  lkey_reg    <= rkey;
            OP_DN_CMP:
            begin
                if (pick_right)
                begin
                    idx_reg <= right_idx;
                end
                else if (pick_left)
                begin
                    idx_reg <= left_idx;
                end
            end
            OP_EMIT:
            begin
                out_stat_reg <= res_stat_reg;
                out_key_reg  <= res_key_reg;
                out_occ_reg  <= OCC_W'(count_reg);
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_stat_reg;
    assign m_tdata  = {{(M_TDATA_W - KEY_W - OCC_W){1'b0}}, out_occ_reg, out_key_reg};

    `HPQ_ASSERT(a_count_bound, count_reg <= CW'(DEPTH), "heap count above depth")
    `HPQ_ASSERT_NEXT(a_emit_valid, cmd.op == OP_EMIT, out_valid_reg, "emitted result not presented")

endmodule

// ===== rtl/binary_max_heap_queue_unit.sv =====
// Top level of the binary max-heap priority queue.
//
//  channel  direction  handshake              payload
//  s_*      in         s_tvalid / s_tready    s_tuser: cmd; s_tdata: key_in
//  m_*      out        m_tvalid / m_tready    m_tuser: status; m_tdata: key_out, occupancy
//  cfg_*    in         cfg_we (no wait)       cfg_wdata: capacity
//
// One command is worked at a time; the key store (one write and one
// registered read per cycle) sets the pace. An insert reads and compares the
// parent once per level climbed; a remove reads the root and the last entry,
// then reads the left child, the right child and compares once per level descended.
// A refused insert or an empty remove goes straight to the done state.
// A new command is taken while the previous result still waits on m_*.
// Reset clears the count and sets capacity to 1024; key store contents are not
// cleared, only entries below the count are ever used.
// An m_* stall holds the finished result and the sequencer in its done state.
module binary_max_heap_queue_unit import hpq_pkg::*; #(
    parameter int DEPTH = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // slave stream: one command per beat
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [KEY_W-1:0]     s_tdata,   // [31:0] key_in
    input  logic                 s_tuser,   // [0] cmd
    // master stream: one result per beat
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] key_out, [42:32] occupancy, rest zero
    output logic [STAT_W-1:0]    m_tuser,   // [1:0] status
    // capacity register
    input  logic                 cfg_we,
    input  logic [CAP_W-1:0]     cfg_wdata
);

    hpq_cmd_t    cmd;
    hpq_status_t status;

    // sequencer: decides each step from datapath status
    hpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: key store, sift registers and the output result register
    hpq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_key    (s_tdata),
        .in_cmd    (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== dv/binary_max_heap_queue_checker.sv =====
// Checker for the heap queue: predicts each result and compares it with the master beats.
module binary_max_heap_queue_checker import hpq_pkg::*; #(
    parameter int DEPTH = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [KEY_W-1:0]     s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [STAT_W-1:0]    m_tuser,
    input  logic                 cfg_we,
    input  logic [CAP_W-1:0]     cfg_wdata,
    output int                   fail_count,
    output int                   pending,
    output int                   insert_cnt,
    output int                   remove_cnt,
    output int                   full_cnt,
    output int                   empty_cnt,
    output int                   peak_occ
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        hpq_stat_t            status;
        logic [KEY_W-1:0]     key;
        logic [OCC_W-1:0]     occ;
    } heap_result_t;

    heap_result_t            awaited_q[$];
    logic signed [KEY_W-1:0] heap_keys [DEPTH];
    int unsigned             held;
    logic [CAP_W-1:0]        cap_reg;
    int                      result_idx;

    task automatic report_mismatch(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
        $display("%0t ns  result %0d  MISMATCH %s: got 0x%0h, want 0x%0h",
                 $time, result_idx, what, got, want);
        fail_count++;
    endtask

    // Run one command against the shadow heap and return the result it yields.
    function automatic heap_result_t apply_command(logic cmd, logic signed [KEY_W-1:0] key);
        heap_result_t            res;
        int unsigned             lim;
        int unsigned             i;
        int unsigned             p;
        int unsigned             l;
        int unsigned             r;
        int unsigned             m;
        logic signed [KEY_W-1:0] t;
        res.status = STAT_OK;
        res.key    = KEY_NONE;
        lim = (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
        if (cmd == CMD_INSERT) begin
            if (held >= lim) begin
                res.status = STAT_FULL;
            end else begin
                i = held;
                heap_keys[i] = key;
                held++;
                while (i > 0) begin
                    p = (i - 1) / 2;
                    if (heap_keys[p] < heap_keys[i]) begin
                        t            = heap_keys[p];
                        heap_keys[p] = heap_keys[i];
                        heap_keys[i] = t;
                        i            = p;
                    end else begin
                        break;
                    end
                end
            end
        end else begin
            if (held == 0) begin
                res.status = STAT_EMPTY;
                res.key    = KEY_EMPTY;
            end else begin
                res.key = heap_keys[0];
                held--;
                heap_keys[0] = heap_keys[held];
                i = 0;
                while (i < held) begin
                    l = 2 * i + 1;
                    r = 2 * i + 2;
                    m = i;
                    if (l < held && heap_keys[l] > heap_keys[m])
                        m = l;
                    if (r < held && heap_keys[r] > heap_keys[m])
                        m = r;
                    if (m == i)
                        break;
                    t            = heap_keys[m];
                    heap_keys[m] = heap_keys[i];
                    heap_keys[i] = t;
                    i            = m;
                end
            end
        end
        res.occ = OCC_W'(held);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        heap_result_t want;
        heap_result_t got;
        if (!rst_n)
        begin
            awaited_q.delete();
            held       = 0;
            cap_reg    = CAP_RESET;
            pending    = 0;
            fail_count = 0;
            insert_cnt = 0;
            remove_cnt = 0;
            full_cnt   = 0;
            empty_cnt  = 0;
            peak_occ   = 0;
            result_idx = 0;
        end
        else
        begin
            // compare first: a result can never come with its own command
            if (m_tvalid && m_tready)
            begin
                got.status = hpq_stat_t'(m_tuser);
                got.key    = m_tdata[KEY_W-1:0];
                got.occ    = m_tdata[KEY_W+OCC_W-1:KEY_W];
                if (awaited_q.size() == 0)
                begin
                    report_mismatch("result beat with nothing outstanding", got.key, '0);
                end
                else
                begin
                    want = awaited_q.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", KEY_W'(got.status), KEY_W'(want.status));
                    if (got.key !== want.key)
                        report_mismatch("key_out", got.key, want.key);
                    if (got.occ !== want.occ)
                        report_mismatch("occupancy", KEY_W'(got.occ), KEY_W'(want.occ));
                end
                if (m_tdata[M_TDATA_W-1:KEY_W+OCC_W] !== '0)
                    report_mismatch("tdata padding", KEY_W'(m_tdata[M_TDATA_W-1:KEY_W+OCC_W]), '0);
                result_idx++;
            end
            if (cfg_we)
                cap_reg = cfg_wdata;
            if (s_tvalid && s_tready)
            begin
                want = apply_command(s_tuser, s_tdata);
                awaited_q = {awaited_q, want};
                if (s_tuser == CMD_INSERT)
                    insert_cnt++;
                else
                    remove_cnt++;
                if (want.status == STAT_FULL)
                    full_cnt++;
                if (want.status == STAT_EMPTY)
                    empty_cnt++;
                if (int'(want.occ) > peak_occ)
                    peak_occ = int'(want.occ);
            end
            pending = awaited_q.size();
        end
    end

endmodule

// ===== dv/tb_binary_max_heap_queue_unit.sv =====
// Testbench top: drives commands and capacity writes into the heap queue and reports the verdict.
module tb_binary_max_heap_queue_unit import hpq_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 1024;
    localparam int CYCLE_LIMIT = 1_000_000;
    // leave room after the last beat
    localparam int TAIL_CYCLES = 80;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [KEY_W-1:0]     s_tdata;     // [31:0] key_in
    logic                 s_tuser;     // [0] cmd
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;     // [31:0] key_out, [42:32] occupancy, rest zero
    logic [STAT_W-1:0]    m_tuser;     // [1:0] status
    logic                 cfg_we;
    logic [CAP_W-1:0]     cfg_wdata;   // capacity

    int    fail_count;
    int    pending;
    int    insert_cnt;
    int    remove_cnt;
    int    full_cnt;
    int    empty_cnt;
    int    peak_occ;
    int    cycles;
    bit    tx_gaps;      // sender inserts idle bursts
    bit    rx_stalls;    // receiver drops tready in bursts
    string cap_trail;

    binary_max_heap_queue_unit #(
        .DEPTH (DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    binary_max_heap_queue_checker #(
        .DEPTH (DEPTH)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending),
        .insert_cnt (insert_cnt),
        .remove_cnt (remove_cnt),
        .full_cnt   (full_cnt),
        .empty_cnt  (empty_cnt),
        .peak_occ   (peak_occ)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Result side: accept by default, drop tready in random bursts while stalls are enabled.
    // Each pass of the loop makes one assignment at one negedge.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_stalls && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15) - 1) @(negedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Present one command beat at the falling edge and hold it until it is taken.
    // Valid stays high on return so back-to-back beats never toggle it.
    task automatic push_cmd(logic cmd, logic [KEY_W-1:0] key);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= key;
        do @(posedge clk); while (!s_tready);
    endtask

    // Drop valid; n sets how long it stays low.
    task automatic hold_off(int n);
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Drop valid and hold until every predicted result has been seen.
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // Write the capacity only with the unit idle: drain, let the sequencer settle, write.
    task automatic set_capacity(int cap);
        wait_drained();
        repeat (2) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= CAP_W'(cap);
        @(negedge clk);
        cfg_we    <= 1'b0;
        cap_trail = {cap_trail, $sformatf(" %0d", cap)};
    endtask

    // Mostly full-width random keys; a narrow band around zero to force ties,
    // and now and then one of the extremes, zero or minus one.
    function automatic logic [KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return $urandom;
        if (sel < 9)
            return KEY_W'($urandom_range(0, 15)) - KEY_W'(8);
        case ($urandom_range(0, 3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return KEY_NONE;
            default: return KEY_EMPTY;
        endcase
    endfunction

    // Random command stream; remove_pm is the share of removes in parts per thousand.
    task automatic run_mix(int n, int remove_pm);
        for (int k = 0; k < n; k++)
        begin
            if (tx_gaps && $urandom_range(0, 5) == 0)
                hold_off($urandom_range(1, 15));
            else if (tx_gaps && $urandom_range(0, 299) == 0)
                wait_drained();
            push_cmd(($urandom_range(0, 999) < remove_pm) ? CMD_REMOVE : CMD_INSERT, pick_key());
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_INSERT;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        tx_gaps   = 1'b0;
        rx_stalls = 1'b1;
        cap_trail = " 1024(reset)";
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // --- directed: reset capacity ---
        // remove on an empty heap
        push_cmd(CMD_REMOVE, $urandom);
        // key extremes, zero, minus one, a tie and a duplicate of the maximum
        push_cmd(CMD_INSERT, 32'h7FFF_FFFF);
        push_cmd(CMD_INSERT, 32'h8000_0000);
        push_cmd(CMD_INSERT, KEY_NONE);
        push_cmd(CMD_INSERT, KEY_EMPTY);
        push_cmd(CMD_INSERT, 32'd5);
        push_cmd(CMD_INSERT, 32'd5);
        push_cmd(CMD_INSERT, 32'h7FFF_FFFF);
        // drain in order, then one more to hit empty again
        repeat (8) push_cmd(CMD_REMOVE, $urandom);

        // zero capacity: every insert is refused
        set_capacity(0);
        push_cmd(CMD_INSERT, $urandom);
        push_cmd(CMD_REMOVE, $urandom);

        // fill a small heap, then overflow it
        set_capacity(3);
        repeat (4) push_cmd(CMD_INSERT, pick_key());

        // shrink capacity below the count: inserts refused, held keys kept
        set_capacity(1);
        push_cmd(CMD_INSERT, pick_key());
        push_cmd(CMD_REMOVE, $urandom);
        push_cmd(CMD_INSERT, pick_key());
        repeat (3) push_cmd(CMD_REMOVE, $urandom);

        // --- random ---
        // single-entry heap
        tx_gaps   = 1'b1;
        rx_stalls = 1'b0;
        set_capacity(1);
        run_mix(60, 500);

        // small random capacity with both sides idling
        rx_stalls = 1'b1;
        set_capacity($urandom_range(2, 40));
        run_mix(100, 450);

        // capacity above DEPTH saturates: fill to the top and push past it
        set_capacity(2047);
        run_mix(1040, 5);

        // capacity far below the count, then a long run of deep sift-downs
        tx_gaps = 1'b0;
        set_capacity(6);
        run_mix(540, 980);

        // closing stretch at full capacity, no idling on either side
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        set_capacity(DEPTH);
        run_mix(60, 350);

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Covered %0d inserts (%0d refused full) and %0d removes (%0d on empty), peak %0d keys.",
                 insert_cnt, full_cnt, remove_cnt, empty_cnt, peak_occ);
        $display("Capacity settings in order:%s", cap_trail);
        if (fail_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
